// ===== rtl/pdmt_pkg.sv =====
package pdmt_pkg;

	localparam int FEATURE_COUNT = 12;
	localparam int MAX_ROWS      = 128;

	localparam int COEF_W     = 16;
	localparam int VAL_W      = 21;
	localparam int DIST_W     = 20;
	localparam int FEAT_DEPTH = MAX_ROWS * FEATURE_COUNT;
	localparam int DIST_DEPTH = (MAX_ROWS * (MAX_ROWS - 1)) / 2;
	localparam int FA_W       = $clog2(FEAT_DEPTH);
	localparam int LC_W       = $clog2(FEAT_DEPTH + 1);
	localparam int DA_W       = $clog2(DIST_DEPTH);
	localparam int DC_W       = $clog2(DIST_DEPTH + 1);
	localparam int RI_W       = $clog2(MAX_ROWS);
	localparam int RC_W       = $clog2(MAX_ROWS + 1);
	localparam int D_W        = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
	localparam int PROD_W     = 2 * COEF_W;
	localparam int ACC_W      = PROD_W + $clog2(FEATURE_COUNT + 1);
	localparam int SQ_RAW     = ACC_W + 4;
	localparam int SQ_W       = SQ_RAW + (SQ_RAW % 2);
	localparam int RT_W       = SQ_W / 2;
	localparam int SC_W       = $clog2(RT_W);
	localparam int CMP_W      = (RT_W > DIST_W) ? RT_W : DIST_W;

	localparam logic [DIST_W-1:0] DIST_MAX    = {DIST_W{1'b1}};
	localparam logic [VAL_W-1:0]  ONE_Q10     = VAL_W'(1024);
	localparam logic [VAL_W-1:0]  FLOOR_RESET = VAL_W'(1);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	typedef struct packed {
		logic load;
		logic comp_init;
		logic mac_issue;
		logic sqrt_load;
		logic sqrt_step;
		logic dist_write;
		logic scan_start;
		logic scan_issue;
		logic sel_update;
		logic thr_set;
		logic rd_issue;
		logic out_dist;
		logic out_thr;
	} cmd_t;

	typedef struct packed {
		logic computed;
		logic has_dist;
		logic few_rows;
		logic last_issue;
		logic pipe_busy;
		logic sqrt_last;
		logic last_pair;
		logic sel_done;
		logic scan_last;
		logic out_busy;
	} sts_t;

endpackage

// ===== rtl/pdmt_ctrl.sv =====
module pdmt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            opcode,
	input  pdmt_pkg::sts_t  sts,
	output pdmt_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MAC   = 4'd1;
	localparam logic [3:0] S_MACW  = 4'd2;
	localparam logic [3:0] S_SQRT  = 4'd3;
	localparam logic [3:0] S_WR    = 4'd4;
	localparam logic [3:0] S_SEL   = 4'd5;
	localparam logic [3:0] S_SCAN  = 4'd6;
	localparam logic [3:0] S_SCANW = 4'd7;
	localparam logic [3:0] S_UPD   = 4'd8;
	localparam logic [3:0] S_FIN   = 4'd9;
	localparam logic [3:0] S_RD    = 4'd10;
	localparam logic [3:0] S_RDW   = 4'd11;

	logic [3:0] state_q, state_d;
	logic       xfer;

	assign in_ready = (state_q == S_IDLE) && !sts.out_busy;
	assign xfer     = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (xfer) begin
					if (opcode == pdmt_pkg::OP_LOAD) begin
						cmd.load = 1'b1;
					end else if (sts.computed) begin
						if (sts.has_dist) begin
							cmd.rd_issue = 1'b1;
							state_d      = S_RDW;
						end else begin
							cmd.out_thr = 1'b1;
						end
					end else if (sts.few_rows) begin
						cmd.out_thr = 1'b1;
					end else begin
						cmd.comp_init = 1'b1;
						state_d       = S_MAC;
					end
				end
			end
			S_MAC: begin
				cmd.mac_issue = 1'b1;
				if (sts.last_issue) state_d = S_MACW;
			end
			S_MACW: begin
				if (!sts.pipe_busy) begin
					cmd.sqrt_load = 1'b1;
					state_d       = S_SQRT;
				end
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (sts.sqrt_last) state_d = S_WR;
			end
			S_WR: begin
				cmd.dist_write = 1'b1;
				state_d        = sts.last_pair ? S_SEL : S_MAC;
			end
			S_SEL: begin
				if (sts.sel_done) begin
					state_d = S_FIN;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (sts.scan_last) state_d = S_SCANW;
			end
			S_SCANW: state_d = S_UPD;
			S_UPD: begin
				cmd.sel_update = 1'b1;
				state_d        = S_SEL;
			end
			S_FIN: begin
				cmd.thr_set = 1'b1;
				state_d     = S_RD;
			end
			S_RD: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_RDW;
			end
			S_RDW: begin
				cmd.out_dist = 1'b1;
				state_d      = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/pdmt_datapath.sv =====
module pdmt_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pdmt_pkg::cmd_t                      cmd,
	output pdmt_pkg::sts_t                      sts,
	input  logic signed [pdmt_pkg::COEF_W-1:0]  coefficient,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pdmt_pkg::VAL_W-1:0]          threshold_floor,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pdmt_pkg::VAL_W-1:0]          value,
	output logic                                is_threshold,
	output logic                                last
);

	logic signed [pdmt_pkg::COEF_W-1:0] feat_mem [pdmt_pkg::FEAT_DEPTH];
	logic [pdmt_pkg::DIST_W-1:0]        dist_mem [pdmt_pkg::DIST_DEPTH];

	logic [pdmt_pkg::VAL_W-1:0]  floor_q;
	logic [pdmt_pkg::LC_W-1:0]   loaded_q;
	logic [pdmt_pkg::D_W-1:0]    col_q;
	logic [pdmt_pkg::RC_W-1:0]   rows_q;
	logic                        computed_q;
	logic [pdmt_pkg::DC_W-1:0]   total_q;
	logic [pdmt_pkg::DC_W-1:0]   rdidx_q;
	logic [pdmt_pkg::VAL_W-1:0]  thr_q;

	logic [pdmt_pkg::RI_W-1:0]   i_q, j_q;
	logic [pdmt_pkg::FA_W-1:0]   ibase_q, jbase_q;
	logic [pdmt_pkg::D_W-1:0]    d_q;

	logic signed [pdmt_pkg::COEF_W-1:0] rd_a_s1, rd_b_s1;
	logic                               rd_v_s1;
	logic [pdmt_pkg::PROD_W-1:0]        prod_s2;
	logic                               prod_v_s2;
	logic [pdmt_pkg::ACC_W-1:0]         acc_q;

	logic [pdmt_pkg::SQ_W-1:0]   x_q;
	logic [pdmt_pkg::RT_W+1:0]   rem_q;
	logic [pdmt_pkg::RT_W-1:0]   root_q;
	logic [pdmt_pkg::SC_W-1:0]   scnt_q;

	logic [pdmt_pkg::DIST_W-1:0] lo_q, hi_q, mid_q, mid;
	logic [pdmt_pkg::DC_W-1:0]   cnt_q;
	logic [pdmt_pkg::DA_W-1:0]   scan_q;
	logic [pdmt_pkg::DIST_W-1:0] dist_rd_s1;
	logic                        dist_v_s1;

	logic                        out_valid_q;
	logic [pdmt_pkg::VAL_W-1:0]  value_q;
	logic                        thr_flag_q;

	logic signed [pdmt_pkg::COEF_W:0]   diff;
	logic [pdmt_pkg::COEF_W-1:0]        mag;
	logic [pdmt_pkg::RT_W+3:0]          rem2;
	logic [pdmt_pkg::RT_W+3:0]          trial;
	logic [pdmt_pkg::CMP_W-1:0]         root_ext;
	logic [pdmt_pkg::DIST_W-1:0]        root_sat;
	logic [pdmt_pkg::VAL_W-1:0]         thr_twice;
	logic [pdmt_pkg::DA_W-1:0]          dist_raddr;
	logic                               load_ok;

	assign cfg_ready = 1'b1;
	assign load_ok   = cmd.load && !computed_q &&
	                   (loaded_q < pdmt_pkg::LC_W'(pdmt_pkg::FEAT_DEPTH));

	assign diff = {rd_a_s1[pdmt_pkg::COEF_W-1], rd_a_s1} - {rd_b_s1[pdmt_pkg::COEF_W-1], rd_b_s1};
	assign mag  = diff[pdmt_pkg::COEF_W] ? pdmt_pkg::COEF_W'(-diff) : pdmt_pkg::COEF_W'(diff);

	assign rem2  = {rem_q, x_q[pdmt_pkg::SQ_W-1 -: 2]};
	assign trial = (pdmt_pkg::RT_W+4)'({root_q, 2'b01});

	assign root_ext = pdmt_pkg::CMP_W'(root_q);
	assign root_sat = (root_ext > pdmt_pkg::CMP_W'(pdmt_pkg::DIST_MAX)) ?
	                  pdmt_pkg::DIST_MAX : pdmt_pkg::DIST_W'(root_ext);

	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign thr_twice = {lo_q, 1'b0};
	assign dist_raddr = cmd.scan_issue ? scan_q : rdidx_q[pdmt_pkg::DA_W-1:0];

	assign sts.computed   = computed_q;
	assign sts.has_dist   = rdidx_q < total_q;
	assign sts.few_rows   = rows_q < pdmt_pkg::RC_W'(2);
	assign sts.last_issue = d_q == pdmt_pkg::D_W'(pdmt_pkg::FEATURE_COUNT - 1);
	assign sts.pipe_busy  = rd_v_s1 || prod_v_s2;
	assign sts.sqrt_last  = scnt_q == pdmt_pkg::SC_W'(pdmt_pkg::RT_W - 1);
	assign sts.last_pair  = (pdmt_pkg::RC_W'(i_q) == rows_q - pdmt_pkg::RC_W'(1)) &&
	                        (j_q == i_q - pdmt_pkg::RI_W'(1));
	assign sts.sel_done   = lo_q == hi_q;
	assign sts.scan_last  = pdmt_pkg::DC_W'(scan_q) == total_q - pdmt_pkg::DC_W'(1);
	assign sts.out_busy   = out_valid_q;

	assign out_valid    = out_valid_q;
	assign value        = value_q;
	assign is_threshold = thr_flag_q;
	assign last         = thr_flag_q;

	// memories and payload
	always_ff @(posedge clk) begin
		if (load_ok) feat_mem[loaded_q[pdmt_pkg::FA_W-1:0]] <= coefficient;
		if (cmd.mac_issue) begin
			rd_a_s1 <= feat_mem[ibase_q + pdmt_pkg::FA_W'(d_q)];
			rd_b_s1 <= feat_mem[jbase_q + pdmt_pkg::FA_W'(d_q)];
		end
		prod_s2 <= pdmt_pkg::PROD_W'(mag) * pdmt_pkg::PROD_W'(mag);
		if (cmd.dist_write) dist_mem[total_q[pdmt_pkg::DA_W-1:0]] <= root_sat;
		if (cmd.scan_issue || cmd.rd_issue) dist_rd_s1 <= dist_mem[dist_raddr];
		if (cmd.sqrt_load) begin
			x_q <= pdmt_pkg::SQ_W'({acc_q, 4'b0000});
		end else if (cmd.sqrt_step) begin
			x_q <= x_q << 2;
		end
		if (cmd.scan_start) mid_q <= mid;
		if (cmd.out_dist) begin
			value_q <= pdmt_pkg::VAL_W'(dist_rd_s1);
		end else if (cmd.out_thr) begin
			value_q <= computed_q ? thr_q : pdmt_pkg::ONE_Q10;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q     <= pdmt_pkg::FLOOR_RESET;
			loaded_q    <= '0;
			col_q       <= '0;
			rows_q      <= '0;
			computed_q  <= 1'b0;
			total_q     <= '0;
			rdidx_q     <= '0;
			thr_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			ibase_q     <= '0;
			jbase_q     <= '0;
			d_q         <= '0;
			rd_v_s1     <= 1'b0;
			prod_v_s2   <= 1'b0;
			acc_q       <= '0;
			rem_q       <= '0;
			root_q      <= '0;
			scnt_q      <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			cnt_q       <= '0;
			scan_q      <= '0;
			dist_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			thr_flag_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) floor_q <= threshold_floor;

			if (load_ok) begin
				loaded_q <= loaded_q + pdmt_pkg::LC_W'(1);
				if (col_q == pdmt_pkg::D_W'(pdmt_pkg::FEATURE_COUNT - 1)) begin
					col_q  <= '0;
					rows_q <= rows_q + pdmt_pkg::RC_W'(1);
				end else begin
					col_q <= col_q + pdmt_pkg::D_W'(1);
				end
			end

			rd_v_s1   <= cmd.mac_issue;
			prod_v_s2 <= rd_v_s1;
			dist_v_s1 <= cmd.scan_issue;

			if (cmd.comp_init) begin
				i_q     <= pdmt_pkg::RI_W'(1);
				j_q     <= '0;
				ibase_q <= pdmt_pkg::FA_W'(pdmt_pkg::FEATURE_COUNT);
				jbase_q <= '0;
				d_q     <= '0;
				acc_q   <= '0;
				total_q <= '0;
				lo_q    <= '0;
				hi_q    <= pdmt_pkg::DIST_MAX;
			end else begin
				if (cmd.mac_issue) begin
					d_q <= sts.last_issue ? '0 : d_q + pdmt_pkg::D_W'(1);
				end
				if (prod_v_s2) acc_q <= acc_q + pdmt_pkg::ACC_W'(prod_s2);
				if (cmd.dist_write) begin
					acc_q   <= '0;
					total_q <= total_q + pdmt_pkg::DC_W'(1);
					if (j_q == i_q - pdmt_pkg::RI_W'(1)) begin
						i_q     <= i_q + pdmt_pkg::RI_W'(1);
						j_q     <= '0;
						ibase_q <= ibase_q + pdmt_pkg::FA_W'(pdmt_pkg::FEATURE_COUNT);
						jbase_q <= '0;
					end else begin
						j_q     <= j_q + pdmt_pkg::RI_W'(1);
						jbase_q <= jbase_q + pdmt_pkg::FA_W'(pdmt_pkg::FEATURE_COUNT);
					end
				end
				if (cmd.sel_update) begin
					if (cnt_q > (total_q >> 1)) begin
						hi_q <= mid_q;
					end else begin
						lo_q <= mid_q + pdmt_pkg::DIST_W'(1);
					end
				end
			end

			if (cmd.sqrt_load) begin
				rem_q  <= '0;
				root_q <= '0;
				scnt_q <= '0;
			end else if (cmd.sqrt_step) begin
				scnt_q <= scnt_q + pdmt_pkg::SC_W'(1);
				if (rem2 >= trial) begin
					rem_q  <= (pdmt_pkg::RT_W+2)'(rem2 - trial);
					root_q <= {root_q[pdmt_pkg::RT_W-2:0], 1'b1};
				end else begin
					rem_q  <= (pdmt_pkg::RT_W+2)'(rem2);
					root_q <= {root_q[pdmt_pkg::RT_W-2:0], 1'b0};
				end
			end

			if (cmd.scan_start) begin
				scan_q <= '0;
				cnt_q  <= '0;
			end else begin
				if (cmd.scan_issue) scan_q <= scan_q + pdmt_pkg::DA_W'(1);
				if (dist_v_s1 && (dist_rd_s1 <= mid_q)) cnt_q <= cnt_q + pdmt_pkg::DC_W'(1);
			end

			if (cmd.thr_set) begin
				thr_q      <= (thr_twice > floor_q) ? thr_twice : floor_q;
				computed_q <= 1'b1;
				rdidx_q    <= '0;
			end

			if (cmd.out_dist) begin
				rdidx_q <= rdidx_q + pdmt_pkg::DC_W'(1);
			end

			if (cmd.out_thr) begin
				loaded_q   <= '0;
				col_q      <= '0;
				rows_q     <= '0;
				computed_q <= 1'b0;
				total_q    <= '0;
				rdidx_q    <= '0;
			end

			if (cmd.out_dist || cmd.out_thr) begin
				out_valid_q <= 1'b1;
				thr_flag_q  <= cmd.out_thr;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_load_locked: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && computed_q) |=> $stable(loaded_q))
		else $error("load changed window after compute");
	a_rdidx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rdidx_q <= total_q)
		else $error("read index beyond distance count");
	a_out_dist_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_dist |-> (computed_q && (rdidx_q < total_q)))
		else $error("distance output with none pending");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_dist || cmd.out_thr) |-> !out_valid_q)
		else $error("result overwrote a pending transfer");
`endif

endmodule

// ===== rtl/pairwise_distance_median_threshold_top.sv =====
// Pairwise distance window with median threshold.
// Input channel (in_valid/in_ready, opcode, coefficient): opcode 0 loads one
// signed Q7.8 coefficient, FEATURE_COUNT of them form one row; opcode 1 fetches.
// Output channel (out_valid/out_ready, value, is_threshold, last): one transfer
// per fetch, the distances in lower-triangle order, then the threshold with
// is_threshold and last set, which also empties the window.
// Config channel (cfg_valid/cfg_ready, threshold_floor): always ready.
// A load is written straight into the feature memory. A later fetch puts its
// distance, read from the distance memory, or the threshold into the output
// register. The first fetch of a window with two rows or more runs the compute
// for all P pairs (MAC over one feature memory with two read ports,
// one-bit-per-cycle square root), then the median search, a counting pass over
// the distance memory per result bit. One item is worked on at a time; a new
// transfer is taken only once the output register is empty.
// Reset empties the window and sets threshold_floor to 1. If the receiver
// stalls, the result holds in the output register and in_ready stays low.
module pairwise_distance_median_threshold_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic signed [pdmt_pkg::COEF_W-1:0]  coefficient,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pdmt_pkg::VAL_W-1:0]          value,
	output logic                                is_threshold,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pdmt_pkg::VAL_W-1:0]          threshold_floor
);

	pdmt_pkg::cmd_t cmd;
	pdmt_pkg::sts_t sts;

	pdmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	pdmt_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.coefficient     (coefficient),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.threshold_floor (threshold_floor),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.value           (value),
		.is_threshold    (is_threshold),
		.last            (last)
	);

endmodule

// ===== test/pairwise_distance_median_threshold_top_tb.sv =====
module pairwise_distance_median_threshold_top_tb;

	typedef struct {
		logic [pdmt_pkg::VAL_W-1:0] value;
		logic                       thr;
		logic                       lst;
	} result_t;

	typedef struct {
		logic                               op;
		logic signed [pdmt_pkg::COEF_W-1:0] coef;
		bit                                 typed;
		logic [pdmt_pkg::VAL_W-1:0]         value;
		logic                               thr;
		logic                               lst;
	} plan_row_t;

	logic                               clk;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_ready;
	logic                               opcode;
	logic signed [pdmt_pkg::COEF_W-1:0] coefficient;
	logic                               out_valid;
	logic                               out_ready;
	logic [pdmt_pkg::VAL_W-1:0]         value;
	logic                               is_threshold;
	logic                               last;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [pdmt_pkg::VAL_W-1:0]         threshold_floor;

	// typed expectation travels with the item
	bit               item_typed;
	result_t          item_result;

	// predictor state
	logic signed [pdmt_pkg::COEF_W-1:0] feat_mem [pdmt_pkg::FEAT_DEPTH];
	logic [pdmt_pkg::DIST_W-1:0]        pair_dist [$];
	int unsigned                        coef_count;
	int unsigned                        next_pair;
	bit                                 window_built;
	logic [pdmt_pkg::VAL_W-1:0]         window_thr;
	logic [pdmt_pkg::VAL_W-1:0]         floor_reg;

	result_t     pending [$];
	int          mismatches;
	int unsigned results_seen;
	int unsigned thresholds_seen;
	int unsigned items_sent;
	int unsigned windows_run;
	int          burst_left;

	pairwise_distance_median_threshold_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.coefficient(coefficient),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value),
		.is_threshold(is_threshold),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.threshold_floor(threshold_floor)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#400000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic longint unsigned root_floor(longint unsigned x);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x = x - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	task automatic build_window();
		int unsigned rows;
		longint unsigned acc;
		longint unsigned root;
		int diff;
		logic [pdmt_pkg::DIST_W-1:0] sorted [$];
		logic [pdmt_pkg::VAL_W-1:0] twice;
		rows = coef_count / pdmt_pkg::FEATURE_COUNT;
		pair_dist.delete();
		for (int i = 1; i < rows; i++) begin
			for (int j = 0; j < i; j++) begin
				acc = 0;
				for (int d = 0; d < pdmt_pkg::FEATURE_COUNT; d++) begin
					diff = int'(feat_mem[i*pdmt_pkg::FEATURE_COUNT+d]) -
						int'(feat_mem[j*pdmt_pkg::FEATURE_COUNT+d]);
					acc += longint'(diff) * longint'(diff);
				end
				root = root_floor(acc << 4);
				pair_dist.push_back(root > pdmt_pkg::DIST_MAX ? pdmt_pkg::DIST_MAX :
					pdmt_pkg::DIST_W'(root));
			end
		end
		if (pair_dist.size() == 0) begin
			window_thr = pdmt_pkg::ONE_Q10;
		end else begin
			sorted = pair_dist;
			sorted.sort();
			twice = {sorted[sorted.size()/2], 1'b0};
			window_thr = (twice > floor_reg) ? twice : floor_reg;
		end
		next_pair = 0;
		window_built = 1;
	endtask

	task automatic track_item(logic op, logic signed [pdmt_pkg::COEF_W-1:0] coef,
			output bit produced, output result_t res);
		produced = 0;
		if (op == pdmt_pkg::OP_LOAD) begin
			if (!window_built && coef_count < pdmt_pkg::FEAT_DEPTH) begin
				feat_mem[coef_count] = coef;
				coef_count++;
			end
		end else begin
			if (!window_built)
				build_window();
			produced = 1;
			if (next_pair < pair_dist.size()) begin
				res = '{pdmt_pkg::VAL_W'(pair_dist[next_pair]), 1'b0, 1'b0};
				next_pair++;
			end else begin
				res = '{window_thr, 1'b1, 1'b1};
				coef_count = 0;
				next_pair = 0;
				window_built = 0;
				pair_dist.delete();
			end
		end
	endtask

	always @(posedge clk) begin
		bit produced;
		result_t res;
		result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				floor_reg = threshold_floor;
			if (in_valid && in_ready) begin
				track_item(opcode, coefficient, produced, res);
				if (produced)
					pending.push_back(item_typed ? item_result : res);
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (is_threshold)
					thresholds_seen++;
				if (pending.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer: value=%0d thr=%0b last=%0b",
							value, is_threshold, last);
				end else begin
					want = pending.pop_front();
					if (value !== want.value || is_threshold !== want.thr ||
						last !== want.lst) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp value=%0d thr=%0b last=%0b, got value=%0d thr=%0b last=%0b",
								want.value, want.thr, want.lst, value, is_threshold, last);
					end
				end
			end
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		int unsigned mode;
		int unsigned phase;
		if (phase == 0)
			mode = $urandom_range(0, 3);
		phase = (phase + 1) % 48;
		case (mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= (phase % 4 == 0);
			default: out_ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	task automatic send(logic op, logic signed [pdmt_pkg::COEF_W-1:0] coef, bit typed = 0,
			result_t res = '{0, 0, 0});
		in_valid <= 1'b1;
		opcode <= op;
		coefficient <= coef;
		item_typed <= typed;
		item_result <= res;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_floor(logic [pdmt_pkg::VAL_W-1:0] v);
		cfg_valid <= 1'b1;
		threshold_floor <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [pdmt_pkg::COEF_W-1:0] pick_coef();
		case ($urandom_range(0, 6))
			0: return 16'sh7FFF;
			1: return -16'sh8000;
			2: return pdmt_pkg::COEF_W'($urandom_range(0, 512)) - 16'sd256;
			default: return pdmt_pkg::COEF_W'($urandom);
		endcase
	endfunction

	task automatic run_window(int rows, int extra, bit noisy);
		logic signed [pdmt_pkg::COEF_W-1:0] prev_row [pdmt_pkg::FEATURE_COUNT];
		logic signed [pdmt_pkg::COEF_W-1:0] c;
		int kept;
		int fetches;
		bit dup;
		for (int r = 0; r < rows; r++) begin
			dup = (r > 0) && ($urandom_range(0, 5) == 0);
			for (int d = 0; d < pdmt_pkg::FEATURE_COUNT; d++) begin
				c = dup ? prev_row[d] : pick_coef();
				prev_row[d] = c;
				send(pdmt_pkg::OP_LOAD, c);
			end
		end
		for (int e = 0; e < extra; e++)
			send(pdmt_pkg::OP_LOAD, pick_coef());
		kept = (rows > pdmt_pkg::MAX_ROWS) ? pdmt_pkg::MAX_ROWS : rows;
		fetches = kept * (kept - 1) / 2 + 1;
		for (int f = 0; f < fetches; f++) begin
			send(pdmt_pkg::OP_FETCH, pdmt_pkg::COEF_W'($urandom));
			if (noisy && f + 1 < fetches && $urandom_range(0, 7) == 0)
				send(pdmt_pkg::OP_LOAD, pick_coef());
		end
		windows_run++;
	endtask

	initial begin
		plan_row_t plan [];
		int unsigned small_items;
		int w;
		int rows;
		int waited;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = pdmt_pkg::OP_LOAD;
		coefficient = '0;
		item_typed = 0;
		item_result = '{0, 0, 0};
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		threshold_floor = pdmt_pkg::FLOOR_RESET;
		coef_count = 0;
		next_pair = 0;
		window_built = 0;
		window_thr = '0;
		floor_reg = pdmt_pkg::FLOOR_RESET;
		mismatches = 0;
		burst_left = 12;
		plan = '{
			'{pdmt_pkg::OP_FETCH, 16'sd0,     1, pdmt_pkg::ONE_Q10, 1'b1, 1'b1},
			'{pdmt_pkg::OP_LOAD,  16'sh7FFF,  0, 0, 1'b0, 1'b0},
			'{pdmt_pkg::OP_LOAD,  -16'sh8000, 0, 0, 1'b0, 1'b0},
			'{pdmt_pkg::OP_LOAD,  16'sd0,     0, 0, 1'b0, 1'b0},
			'{pdmt_pkg::OP_LOAD,  -16'sd1,    0, 0, 1'b0, 1'b0},
			'{pdmt_pkg::OP_LOAD,  16'sd1,     0, 0, 1'b0, 1'b0},
			'{pdmt_pkg::OP_FETCH, -16'sd1,    1, pdmt_pkg::ONE_Q10, 1'b1, 1'b1},
			'{pdmt_pkg::OP_FETCH, 16'sh7FFF,  1, pdmt_pkg::ONE_Q10, 1'b1, 1'b1}
		};
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[k])
			send(plan[k].op, plan[k].coef, plan[k].typed,
				'{plan[k].value, plan[k].thr, plan[k].lst});
		drain();

		// two-row window with the floor at its maximum, then three rows with the floor at zero
		write_floor('1);
		run_window(2, 0, 0);
		drain();
		write_floor('0);
		run_window(3, 5, 1);
		drain();

		small_items = 0;
		w = 0;
		while (small_items < 400) begin
			if ($urandom_range(0, 2) == 0) begin
				drain();
				case ($urandom_range(0, 3))
					0: write_floor('0);
					1: write_floor('1);
					2: write_floor(pdmt_pkg::VAL_W'($urandom_range(0, 4096)));
					default: write_floor(pdmt_pkg::VAL_W'($urandom));
				endcase
			end
			if (w == 3) begin
				drain();
				run_window(pdmt_pkg::MAX_ROWS + 2, 7, 1);
			end else begin
				case ($urandom_range(0, 7))
					0: rows = $urandom_range(0, 1);
					default: rows = $urandom_range(2, 6);
				endcase
				waited = items_sent;
				run_window(rows, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0,
					$urandom_range(0, 1));
				small_items += items_sent - waited;
			end
			w++;
		end

		in_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (pending.size() != 0)
			mismatches++;
		$display("covered %0d windows, %0d items, %0d results, %0d thresholds",
			windows_run, items_sent, results_seen, thresholds_seen);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("mismatches: %0d", mismatches);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== pairwise_distance_median_threshold_top.f =====
rtl/pdmt_pkg.sv
rtl/pdmt_ctrl.sv
rtl/pdmt_datapath.sv
rtl/pairwise_distance_median_threshold_top.sv
test/pairwise_distance_median_threshold_top_tb.sv
